### rtl/core/glp_pkg.sv
// ----------------------------------------------------------------------------
// glp_pkg: shared types and constants for the gate line parser
// Character codes, token classes, status codes and the decimal helpers.
// ----------------------------------------------------------------------------
package glp_pkg;

  // Width of the wire and id accumulators (16 to 64).
  localparam int INDEX_BITS = 64;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;

  // Token classes
  localparam logic [1:0] CLS_NL    = 2'd0;
  localparam logic [1:0] CLS_SP    = 2'd1;
  localparam logic [1:0] CLS_CM    = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  // Result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NONDIGIT  = 2'd1;
  localparam logic [1:0] ST_EARLY_END = 2'd2;

  typedef logic [INDEX_BITS-1:0] index_t;

  typedef struct packed {
    logic [1:0] cls;
    logic       is_digit;
    logic [7:0] offs;      // character minus '0', modulo 256
  } token_t;

  typedef struct packed {
    logic [63:0] wire_a;
    logic [63:0] wire_b;
    logic [7:0]  truth_table;
    logic [1:0]  gate_arity;
    logic [63:0] gate_id;
    logic [7:0]  output_flag;
    logic [7:0]  party_num;
    logic [1:0]  status;
  } result_t;

  // acc * 10 + d, as two shifts and adds
  function automatic index_t dec_index(index_t acc, logic [3:0] d);
    return (acc << 3) + (acc << 1) + INDEX_BITS'(d);
  endfunction

  function automatic logic [7:0] dec_byte(logic [7:0] acc, logic [3:0] d);
    return (acc << 3) + (acc << 1) + {4'b0, d};
  endfunction

  function automatic logic [7:0] shift_table(logic [7:0] acc, logic [7:0] offs);
    return {acc[6:0], 1'b0} + offs;
  endfunction

endpackage

### rtl/core/glp_front.sv
// ----------------------------------------------------------------------------
// glp_front: input side of the gate line parser
// Takes character transfers and turns each into a classified token.
// ----------------------------------------------------------------------------
module glp_front (
  input  logic            in_valid,
  input  logic [7:0]      in_char_in,
  input  logic            q_full,
  output logic            in_stall,
  output logic            push,
  output glp_pkg::token_t tok
);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    tok.offs     = in_char_in - glp_pkg::CH_ZERO;
    tok.is_digit = (in_char_in >= glp_pkg::CH_ZERO) && (in_char_in <= glp_pkg::CH_NINE);
    if (in_char_in == glp_pkg::CH_NL) begin
      tok.cls = glp_pkg::CLS_NL;
    end else if (in_char_in == glp_pkg::CH_SPACE) begin
      tok.cls = glp_pkg::CLS_SP;
    end else if (in_char_in == glp_pkg::CH_COMMA) begin
      tok.cls = glp_pkg::CLS_CM;
    end else begin
      tok.cls = glp_pkg::CLS_OTHER;
    end
  end

endmodule

### rtl/core/glp_queue.sv
// ----------------------------------------------------------------------------
// glp_queue: two-entry token queue
// Decouples the classifier from the parse engine.
// ----------------------------------------------------------------------------
module glp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  glp_pkg::token_t push_tok,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output glp_pkg::token_t head
);

  glp_pkg::token_t q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

### rtl/core/glp_back.sv
// ----------------------------------------------------------------------------
// glp_back: parse engine of the gate line parser
// Runs the field state machine and accumulators; holds the result register.
// ----------------------------------------------------------------------------
module glp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tok_valid,
  input  glp_pkg::token_t  tok,
  input  logic             out_stall,
  output logic             pop,
  output logic             res_valid,
  output glp_pkg::result_t res
);

  localparam logic [2:0] PH_WIRE_A = 3'd0;
  localparam logic [2:0] PH_SECOND = 3'd1;
  localparam logic [2:0] PH_TABLE  = 3'd2;
  localparam logic [2:0] PH_ID     = 3'd3;
  localparam logic [2:0] PH_OUTPUT = 3'd4;
  localparam logic [2:0] PH_PARTY  = 3'd5;
  localparam logic [2:0] PH_SKIP   = 3'd6;

  logic [2:0]      phase_r, phase_nxt;
  glp_pkg::index_t wire_a_r, wire_a_nxt;
  glp_pkg::index_t wire_b_r, wire_b_nxt;
  glp_pkg::index_t id_r, id_nxt;
  logic [7:0]      table_r, table_nxt;
  logic [7:0]      outf_r, outf_nxt;
  logic [7:0]      party_r, party_nxt;
  logic            two_r, two_nxt;

  logic             valid_r;
  glp_pkg::result_t res_r;
  glp_pkg::result_t res_nxt;
  logic             emit;
  logic             clear;
  logic             nl, sp, cm;
  logic [3:0]       dig;

  assign pop       = tok_valid && (!valid_r || !out_stall);
  assign res_valid = valid_r;
  assign res       = res_r;

  assign nl  = (tok.cls == glp_pkg::CLS_NL);
  assign sp  = (tok.cls == glp_pkg::CLS_SP);
  assign cm  = (tok.cls == glp_pkg::CLS_CM);
  assign dig = tok.offs[3:0];

  always_comb begin
    phase_nxt  = phase_r;
    wire_a_nxt = wire_a_r;
    wire_b_nxt = wire_b_r;
    id_nxt     = id_r;
    table_nxt  = table_r;
    outf_nxt   = outf_r;
    party_nxt  = party_r;
    two_nxt    = two_r;
    emit       = 1'b0;
    clear      = 1'b0;
    res_nxt    = '0;

    unique case (phase_r) inside
      PH_WIRE_A, PH_SECOND, PH_TABLE, PH_ID, PH_OUTPUT: begin
        if (nl) begin
          emit           = 1'b1;
          clear          = 1'b1;
          res_nxt.status = glp_pkg::ST_EARLY_END;
        end else if (phase_r == PH_WIRE_A && cm) begin
          phase_nxt = PH_SECOND;
        end else if (phase_r == PH_SECOND && cm) begin
          two_nxt   = 1'b1;
          table_nxt = '0;
          phase_nxt = PH_TABLE;
        end else if (sp && phase_r != PH_WIRE_A) begin
          phase_nxt = (phase_r == PH_ID)     ? PH_OUTPUT :
                      (phase_r == PH_OUTPUT) ? PH_PARTY  : PH_ID;
        end else if (phase_r == PH_TABLE) begin
          // any other character counts as a table digit
          table_nxt = glp_pkg::shift_table(table_r, tok.offs);
        end else if (!tok.is_digit) begin
          emit           = 1'b1;
          phase_nxt      = PH_SKIP;
          res_nxt.status = glp_pkg::ST_NONDIGIT;
        end else begin
          case (phase_r)
            PH_WIRE_A: wire_a_nxt = glp_pkg::dec_index(wire_a_r, dig);
            PH_SECOND: begin
              wire_b_nxt = glp_pkg::dec_index(wire_b_r, dig);
              table_nxt  = glp_pkg::shift_table(table_r, tok.offs);
            end
            PH_ID:     id_nxt   = glp_pkg::dec_index(id_r, dig);
            default:   outf_nxt = glp_pkg::dec_byte(outf_r, dig);
          endcase
        end
      end
      PH_PARTY: begin
        if (nl || sp) begin
          emit                = 1'b1;
          res_nxt.wire_a      = 64'(wire_a_r);
          res_nxt.wire_b      = two_r ? 64'(wire_b_r) : 64'd0;
          res_nxt.truth_table = table_r;
          res_nxt.gate_arity  = two_r ? 2'd2 : 2'd1;
          res_nxt.gate_id     = 64'(id_r);
          res_nxt.output_flag = outf_r;
          res_nxt.party_num   = party_r;
          res_nxt.status      = glp_pkg::ST_OK;
          if (nl) begin
            clear = 1'b1;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end else if (!tok.is_digit) begin
          emit           = 1'b1;
          phase_nxt      = PH_SKIP;
          res_nxt.status = glp_pkg::ST_NONDIGIT;
        end else begin
          party_nxt = glp_pkg::dec_byte(party_r, dig);
        end
      end
      default: begin
        clear = nl;
      end
    endcase

    if (clear) begin
      phase_nxt  = PH_WIRE_A;
      wire_a_nxt = '0;
      wire_b_nxt = '0;
      id_nxt     = '0;
      table_nxt  = '0;
      outf_nxt   = '0;
      party_nxt  = '0;
      two_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WIRE_A;
      wire_a_r <= '0;
      wire_b_r <= '0;
      id_r     <= '0;
      table_r  <= '0;
      outf_r   <= '0;
      party_r  <= '0;
      two_r    <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        phase_r  <= phase_nxt;
        wire_a_r <= wire_a_nxt;
        wire_b_r <= wire_b_nxt;
        id_r     <= id_nxt;
        table_r  <= table_nxt;
        outf_r   <= outf_nxt;
        party_r  <= party_nxt;
        two_r    <= two_nxt;
      end
      if (pop && emit) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res_r <= res_nxt;
    end
  end

endmodule

### rtl/core/gate_line_parser.sv
// ----------------------------------------------------------------------------
// gate_line_parser: character-serial parser for gate netlist lines
// Path: an accepted character is written into the token queue; the parse
// engine takes it from the queue head, and a result it causes is registered
// and shown on the out_ ports. Throughput: one character per cycle while
// the result register can take one; the two-entry queue absorbs output stalls.
// Reset (rst_n low, synchronous): queue empty, no result pending, parser at
// the first wire field with all accumulators cleared.
// ----------------------------------------------------------------------------
module gate_line_parser (
  input  logic        clk,
  input  logic        rst_n,
  // character channel
  input  logic        in_valid,
  input  logic [7:0]  in_char_in,
  output logic        in_stall,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_wire_a,
  output logic [63:0] out_wire_b,
  output logic [7:0]  out_truth_table,
  output logic [1:0]  out_gate_arity,
  output logic [63:0] out_gate_id,
  output logic [7:0]  out_output_flag,
  output logic [7:0]  out_party_num,
  output logic [1:0]  out_status
);

  // Front: classify each character transfer into a token.
  logic            push;
  logic            q_full;
  logic            q_not_empty;
  logic            pop;
  glp_pkg::token_t front_tok;
  glp_pkg::token_t head_tok;
  glp_pkg::result_t res;

  glp_front u_front (
    .in_valid   (in_valid),
    .in_char_in (in_char_in),
    .q_full     (q_full),
    .in_stall   (in_stall),
    .push       (push),
    .tok        (front_tok)
  );

  // Queue: lets the front keep taking characters while a result waits.
  glp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_tok  (front_tok),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_tok)
  );

  // Back: field state machine, accumulators and the result register.
  // A token is consumed only when the result register can take a result.
  glp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (q_not_empty),
    .tok       (head_tok),
    .out_stall (out_stall),
    .pop       (pop),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_wire_a      = res.wire_a;
  assign out_wire_b      = res.wire_b;
  assign out_truth_table = res.truth_table;
  assign out_gate_arity  = res.gate_arity;
  assign out_gate_id     = res.gate_id;
  assign out_output_flag = res.output_flag;
  assign out_party_num   = res.party_num;
  assign out_status      = res.status;

  // Error results carry nothing but the status.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != glp_pkg::ST_OK |->
      out_gate_arity == 2'd0 && out_wire_a == 64'd0 && out_gate_id == 64'd0)
    else $error("error result with nonzero fields");

  // Good results are one or two input gates.
  a_ok_arity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == glp_pkg::ST_OK |->
      out_gate_arity == 2'd1 || out_gate_arity == 2'd2)
    else $error("bad arity on good result");

  // One-input gates report no second wire.
  a_one_input_b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == glp_pkg::ST_OK && out_gate_arity == 2'd1 |->
      out_wire_b == 64'd0)
    else $error("one-input gate with second wire");

  // Status code is never the unused value.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("unused status code");

endmodule

### verif/gate_line_checker.sv
// ----------------------------------------------------------------------------
// gate_line_checker: result predictor and comparator for gate_line_parser
// Follows every character transfer with its own copy of the line parser,
// queues the gate or error it expects, and checks each result transfer
// field by field against the oldest queued entry.
// ----------------------------------------------------------------------------
module gate_line_checker
  import glp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_wire_a,
  input  logic [63:0] out_wire_b,
  input  logic [7:0]  out_truth_table,
  input  logic [1:0]  out_gate_arity,
  input  logic [63:0] out_gate_id,
  input  logic [7:0]  out_output_flag,
  input  logic [7:0]  out_party_num,
  input  logic [1:0]  out_status,
  output int          mismatch_count,
  output int          gates_waiting
);

  typedef enum logic [2:0] {
    FLD_WIRE_A,
    FLD_SECOND,
    FLD_TABLE,
    FLD_ID,
    FLD_OUTPUT,
    FLD_PARTY,
    FLD_SKIP
  } field_t;

  field_t     field;
  index_t     acc_a;
  index_t     acc_b;
  index_t     acc_id;
  logic [7:0] acc_tt;
  logic [7:0] acc_out;
  logic [7:0] acc_party;
  logic       two_in;

  result_t    pending_gates[$];
  int         errs = 0;

  task automatic start_line();
    field     = FLD_WIRE_A;
    acc_a     = '0;
    acc_b     = '0;
    acc_id    = '0;
    acc_tt    = '0;
    acc_out   = '0;
    acc_party = '0;
    two_in    = 1'b0;
  endtask

  // error result: everything zero but the status
  task automatic line_error(input logic [1:0] code);
    result_t r;
    r = '0;
    r.status = code;
    pending_gates.push_back(r);
    if (code == ST_EARLY_END) start_line();
    else field = FLD_SKIP;
  endtask

  task automatic gate_done();
    result_t r;
    r.wire_a      = 64'(acc_a);
    r.wire_b      = two_in ? 64'(acc_b) : 64'd0;
    r.truth_table = acc_tt;
    r.gate_arity  = two_in ? 2'd2 : 2'd1;
    r.gate_id     = 64'(acc_id);
    r.output_flag = acc_out;
    r.party_num   = acc_party;
    r.status      = ST_OK;
    pending_gates.push_back(r);
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic       nl;
    logic       sp;
    logic       cm;
    logic       dig;
    logic [7:0] d;
    nl  = (c == CH_NL);
    sp  = (c == CH_SPACE);
    cm  = (c == CH_COMMA);
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    d   = c - CH_ZERO;
    case (field)
      FLD_WIRE_A: begin
        if (nl) line_error(ST_EARLY_END);
        else if (cm) field = FLD_SECOND;
        else if (!dig) line_error(ST_NONDIGIT);
        else acc_a = acc_a * index_t'(10) + index_t'(d);
      end
      FLD_SECOND: begin
        if (nl) line_error(ST_EARLY_END);
        else if (cm) begin
          two_in = 1'b1;
          acc_tt = '0;
          field  = FLD_TABLE;
        end else if (sp) field = FLD_ID;
        else if (!dig) line_error(ST_NONDIGIT);
        else begin
          // one-input table digits land here too
          acc_b  = acc_b * index_t'(10) + index_t'(d);
          acc_tt = (acc_tt << 1) + d;
        end
      end
      FLD_TABLE: begin
        if (nl) line_error(ST_EARLY_END);
        else if (sp) field = FLD_ID;
        else acc_tt = (acc_tt << 1) + d;
      end
      FLD_ID: begin
        if (nl) line_error(ST_EARLY_END);
        else if (sp) field = FLD_OUTPUT;
        else if (!dig) line_error(ST_NONDIGIT);
        else acc_id = acc_id * index_t'(10) + index_t'(d);
      end
      FLD_OUTPUT: begin
        if (nl) line_error(ST_EARLY_END);
        else if (sp) field = FLD_PARTY;
        else if (!dig) line_error(ST_NONDIGIT);
        else acc_out = acc_out * 8'd10 + d;
      end
      FLD_PARTY: begin
        if (nl || sp) begin
          gate_done();
          if (nl) start_line();
          else field = FLD_SKIP;
        end else if (!dig) line_error(ST_NONDIGIT);
        else acc_party = acc_party * 8'd10 + d;
      end
      default: begin
        if (nl) start_line();
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      start_line();
      pending_gates.delete();
    end else begin
      if (in_valid && !in_stall) parse_char(in_char_in);
      if (out_valid && !out_stall) begin
        if (pending_gates.size() == 0) begin
          $error("result transfer with nothing pending, status %0d", out_status);
          errs++;
        end else begin
          want = pending_gates.pop_front();
          check_field("wire_a", want.wire_a, out_wire_a);
          check_field("wire_b", want.wire_b, out_wire_b);
          check_field("truth_table", 64'(want.truth_table), 64'(out_truth_table));
          check_field("gate_arity", 64'(want.gate_arity), 64'(out_gate_arity));
          check_field("gate_id", want.gate_id, out_gate_id);
          check_field("output_flag", 64'(want.output_flag), 64'(out_output_flag));
          check_field("party_num", 64'(want.party_num), 64'(out_party_num));
          check_field("status", 64'(want.status), 64'(out_status));
        end
      end
    end
    mismatch_count <= errs;
    gates_waiting  <= pending_gates.size();
  end

endmodule

### verif/tb_gate_line_parser.sv
// ----------------------------------------------------------------------------
// tb_gate_line_parser: stimulus and verdict for the gate line parser
// Feeds netlist text one character per transfer: a few hand-made lines for
// the corner cases, then random lines, mostly well formed, some cut short,
// corrupted or pure noise. The sender idles in bursts, the receiver stalls
// in modes; gate_line_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_gate_line_parser;
  import glp_pkg::*;

  localparam int TARGET_CHARS  = 1200;    // stop adding lines past this
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 8;       // two-stage path plus a two-entry queue

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [7:0]  in_char_in = 8'h00;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [63:0] out_wire_a;
  logic [63:0] out_wire_b;
  logic [7:0]  out_truth_table;
  logic [1:0]  out_gate_arity;
  logic [63:0] out_gate_id;
  logic [7:0]  out_output_flag;
  logic [7:0]  out_party_num;
  logic [1:0]  out_status;

  int          mismatches;
  int          gates_waiting;

  // sender state
  logic [7:0]  line_buf[$];   // characters of the line being built
  int          burst_left  = 0;
  int          chars_sent  = 0;
  bit          mid_drained = 1'b0;

  // receiver stall pattern
  int          stall_mode = 0;
  int          stall_left = 0;

  int          cycles = 0;

  gate_line_parser DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_char_in      (in_char_in),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_wire_a      (out_wire_a),
    .out_wire_b      (out_wire_b),
    .out_truth_table (out_truth_table),
    .out_gate_arity  (out_gate_arity),
    .out_gate_id     (out_gate_id),
    .out_output_flag (out_output_flag),
    .out_party_num   (out_party_num),
    .out_status      (out_status)
  );

  gate_line_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_in      (in_char_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_wire_a      (out_wire_a),
    .out_wire_b      (out_wire_b),
    .out_truth_table (out_truth_table),
    .out_gate_arity  (out_gate_arity),
    .out_gate_id     (out_gate_id),
    .out_output_flag (out_output_flag),
    .out_party_num   (out_party_num),
    .out_status      (out_status),
    .mismatch_count  (mismatches),
    .gates_waiting   (gates_waiting)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: picks a mode for a random stretch. Modes are free flowing,
  // light stalls, heavy stalls and a solid hold, so the token queue sees
  // empty, full and everything in between.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(5, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= 1'b1;
    endcase
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One character transfer. A new burst may open with an idle gap; inside a
  // burst valid stays high from one character to the next. The payload is
  // held until the edge that takes it.
  task automatic send_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_char_in <= c;
    do @(posedge clk); while (in_stall);
    chars_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i]);
    line_buf.delete();
  endtask

  // Hold the sender off until every predicted result has been seen. The
  // first edge lets the checker count the last character sent.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (gates_waiting != 0) @(posedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // Mostly short fields; now and then long enough to wrap 64 bits
  function automatic int num_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 3);
  endfunction

  task automatic push_number(input int len);
    for (int i = 0; i < len; i++) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Builds one random line into line_buf, always ending in a newline.
  task automatic build_line();
    int         kind;
    int         cut;
    int         idx;
    int         n;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    push_number(num_len());
    line_buf.push_back(CH_COMMA);
    if ($urandom_range(0, 1) == 1) begin
      // two inputs: b, then the table field, which takes any byte but a space or newline as a digit
      push_number(num_len());
      line_buf.push_back(CH_COMMA);
      if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) begin
          b = any_byte();
          if (b == CH_SPACE || b == CH_NL) b = 8'h7f;
          line_buf.push_back(b);
        end
      end else begin
        for (int i = 0; i < 4; i++) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 1)));
      end
    end else begin
      // one input: the table digits sit in the second field
      n = ($urandom_range(0, 7) == 0) ? num_len() : 2;
      for (int i = 0; i < n; i++) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 1)));
    end
    line_buf.push_back(CH_SPACE);
    push_number(num_len());
    line_buf.push_back(CH_SPACE);
    push_number(num_len());
    line_buf.push_back(CH_SPACE);
    push_number(num_len());
    if ($urandom_range(0, 9) < 3) begin
      // party closed by a space, trailing junk skipped
      line_buf.push_back(CH_SPACE);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) line_buf.push_back(any_byte());
    end
    line_buf.push_back(CH_NL);

    if (kind >= 70 && kind < 85) begin
      // cut short: newline anywhere, down to an empty line
      cut = $urandom_range(0, line_buf.size() - 2);
      while (line_buf.size() > cut) void'(line_buf.pop_back());
      line_buf.push_back(CH_NL);
    end else if (kind >= 85 && kind < 95) begin
      idx = $urandom_range(0, line_buf.size() - 2);
      line_buf[idx] = any_byte();
    end else if (kind >= 95) begin
      line_buf.delete();
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) line_buf.push_back(any_byte());
      line_buf.push_back(CH_NL);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Hand-made lines:
    //  empty line -> early end
    //  empty wire fields, two inputs, non-digit taken as a table digit
    //  one-input gate hitting a non-digit (0xff) in the id field
    //  one-input gate whose second field must read back as zero, party
    //  closed by a space, then a NUL in the skipped tail
    push_text("\n");
    push_text(",,Z 1 2 3\n");
    push_text("9,1 ");
    line_buf.push_back(8'hff);
    push_text("\n");
    push_text("0,5 0 0 7 ");
    line_buf.push_back(8'h00);
    push_text("\n");
    send_line();
    wait_for_drain();

    while (chars_sent < TARGET_CHARS) begin
      build_line();
      send_line();
      // one full pause halfway through, with results still in flight
      if (!mid_drained && chars_sent >= TARGET_CHARS / 2) begin
        wait_for_drain();
        mid_drained = 1'b1;
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && gates_waiting == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

### gate_line_parser.f
rtl/core/glp_pkg.sv
rtl/core/glp_front.sv
rtl/core/glp_queue.sv
rtl/core/glp_back.sv
rtl/core/gate_line_parser.sv
verif/gate_line_checker.sv
verif/tb_gate_line_parser.sv
